// File: rtl/tlpq_pkg.sv
// Shared types, constants and codes for the three-level priority job queue.
`default_nettype none
package tlpq_pkg;

  localparam int LEVEL_DEPTH = 1024;
  localparam int PTR_W       = $clog2(LEVEL_DEPTH);
  localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
  localparam int NUM_LEVELS  = 3;
  localparam int ID_W        = 16;
  localparam int PAGES_W     = 16;
  localparam int ACC_W       = 32;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // priority levels
  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MID  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;
  localparam logic [1:0] LVL_BAD  = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_PUSHED  = 3'd0;
  localparam logic [2:0] STAT_POPPED  = 3'd1;
  localparam logic [2:0] STAT_EMPTY   = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_BADPRIO = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    job_id;
    logic [PAGES_W-1:0] pages;
    logic [1:0]         priority_req;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  out_id;
    logic [2:0]       status;
    logic [ACC_W-1:0] total_time;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_rd;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/tlpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/tlpq_ctrl.sv
// Sequencing state machine for the three-level priority job queue.
`default_nettype none
module tlpq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  tlpq_pkg::dp_stat_t     dp_stat,
  output tlpq_pkg::dp_cmd_t      dp_cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import tlpq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        busy           = 1'b0;
        dp_cmd.capture = start;
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = dp_stat.need_rd ? S_READ : S_DONE;
      end
      S_READ: begin
        dp_cmd.load_rd = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/tlpq_dp.sv
// Datapath: level stores, pointers, counts, page accumulator and result register.
`default_nettype none
module tlpq_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  tlpq_pkg::in_item_t     in_data,
  input  tlpq_pkg::dp_cmd_t      dp_cmd,
  output tlpq_pkg::dp_stat_t     dp_stat,
  output tlpq_pkg::out_item_t    out_data
);
  import tlpq_pkg::*;

  in_item_t         req_r;
  out_item_t        res_r, res_nxt;
  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [NUM_LEVELS];
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [1:0]       rd_lvl_r, rd_lvl_nxt;

  logic [ID_W-1:0]  rdata [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] we, re;

  logic             is_pop;
  logic             pop_any;
  logic [1:0]       pop_lvl;
  logic [1:0]       lvl_idx;
  logic             prio_ok;
  logic             lvl_full;
  logic             push_ok;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sat;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign is_pop  = (req_r.req_type == REQ_POP);
  assign prio_ok = (req_r.priority_req != LVL_BAD);

  // pick the highest non-empty level for a pop
  always_comb begin
    pop_any = 1'b1;
    priority if (cnt_r[LVL_HIGH] != '0) pop_lvl = LVL_HIGH;
    else if (cnt_r[LVL_MID] != '0)      pop_lvl = LVL_MID;
    else if (cnt_r[LVL_LOW] != '0)      pop_lvl = LVL_LOW;
    else begin
      pop_lvl = LVL_LOW;
      pop_any = 1'b0;
    end
  end

  assign lvl_idx  = is_pop ? pop_lvl : (prio_ok ? req_r.priority_req : LVL_LOW);
  assign lvl_full = (cnt_r[lvl_idx] == CNT_W'(LEVEL_DEPTH));
  assign push_ok  = !is_pop && prio_ok && !lvl_full;

  assign acc_sum = {1'b0, acc_r} + {{(ACC_W + 1 - PAGES_W){1'b0}}, req_r.pages};
  assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  assign dp_stat.need_rd = is_pop && pop_any;

  always_comb begin
    res_nxt    = res_r;
    acc_nxt    = acc_r;
    rd_lvl_nxt = rd_lvl_r;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
      we[i]       = 1'b0;
      re[i]       = 1'b0;
    end

    if (dp_cmd.exec) begin
      res_nxt.out_id = '0;
      if (!is_pop) begin
        acc_nxt = acc_sat;
        res_nxt.total_time = acc_sat;
        priority if (!prio_ok) res_nxt.status = STAT_BADPRIO;
        else if (lvl_full)     res_nxt.status = STAT_FULL;
        else                   res_nxt.status = STAT_PUSHED;
      end else begin
        res_nxt.total_time = acc_r;
        res_nxt.status     = pop_any ? STAT_POPPED : STAT_EMPTY;
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (lvl_idx == 2'(i)) begin
          if (push_ok) begin
            we[i]       = 1'b1;
            tail_nxt[i] = ptr_inc(tail_r[i]);
            cnt_nxt[i]  = cnt_r[i] + CNT_W'(1);
          end
          if (is_pop && pop_any) begin
            re[i]       = 1'b1;
            head_nxt[i] = ptr_inc(head_r[i]);
            cnt_nxt[i]  = cnt_r[i] - CNT_W'(1);
          end
        end
      end
      rd_lvl_nxt = pop_lvl;
    end

    if (dp_cmd.load_rd) begin
      res_nxt.out_id = rdata[rd_lvl_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      acc_r <= acc_nxt;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      req_r <= in_data;
    end
    res_r    <= res_nxt;
    rd_lvl_r <= rd_lvl_nxt;
  end

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_store
    tlpq_ram #(
      .WIDTH (ID_W),
      .DEPTH (LEVEL_DEPTH)
    ) u_store (
      .clk   (clk),
      .we    (we[g]),
      .waddr (tail_r[g]),
      .wdata (req_r.job_id),
      .re    (re[g]),
      .raddr (head_r[g]),
      .rdata (rdata[g])
    );
  end

  assign out_data = res_r;

endmodule
`default_nettype wire

// File: rtl/three_level_priority_job_queue.sv
// Top level of the three-level strict-priority job queue.
//
// Usage:
//   Drive in_data and raise start; the request transfers at a rising edge with
//   start high and busy low. A push appends job_id to the level picked by
//   priority_req and adds pages to the saturating total; a pop returns the
//   oldest id of the highest non-empty level.
//   Every request yields one result on out_data, marked by out_valid for
//   exactly one cycle. The receiver cannot stall; the result transfers at the
//   edge that ends that cycle.
//   A push steps the sequencer through execute and result; a pop that finds
//   an item adds a store read state between them for the registered store
//   read, while a pop of an empty queue skips it. busy stays high from the
//   transfer until the result cycle ends, so no new request is taken while
//   one is still in flight.
//   Reset (rst_n low, synchronous) empties all levels and clears the total.
//   The level stores are not cleared; no clearing pass runs, so the block
//   takes requests in the first cycle after reset.
`default_nettype none
module three_level_priority_job_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  tlpq_pkg::in_item_t     in_data,
  output logic                   out_valid,
  output tlpq_pkg::out_item_t    out_data
);
  import tlpq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  tlpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
